// File: rtl/lef_pkg.sv
// Shared definitions for the local extrema finder: default sizes, register
// indexes, reset values and the hit flags carried with each queued result.
// No dependencies.
package lef_pkg;

    localparam int LEF_MAX_WIDTH  = 1024;
    localparam int LEF_MAX_HEIGHT = 1024;
    localparam int LEF_PIXEL_BITS = 8;

    // Depth of the queue between classification and result delivery.
    localparam int LEF_QUEUE_DEPTH = 4;

    // APB byte address bits; registers sit on 32-bit word boundaries.
    localparam int LEF_ADDR_BITS = 5;
    localparam int LEF_DATA_BITS = 32;

    localparam int LEF_RANGE_HIGH_RESET  = 255;
    localparam int LEF_IMAGE_WIDTH_RESET = 640;
    localparam int LEF_IMAGE_HEIGHT_RESET = 480;

    typedef enum logic [2:0] {
        REG_FIND_MINIMA  = 3'd0,
        REG_RANGE_LOW    = 3'd1,
        REG_RANGE_HIGH   = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } lef_reg_t;

    // Which of the two row scans produced a result for a pixel.
    typedef struct packed {
        logic delayed_hit;
        logic last_row_hit;
    } lef_hits_t;

endpackage

// File: rtl/lef_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lef_queue.sv
// Small first-in first-out queue in flip-flops between the front and back ends.
// No dependencies.
module lef_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue pushed while full");

    a_count_tracks : assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("queue count did not grow on a lone push");
`endif

endmodule

// File: rtl/lef_front.sv
// Front end: pixel counters, line stores, 3x3 window and both row scans.
// Depends on lef_pkg and lef_ram; pushes classified results towards lef_queue.
module lef_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int PW = PIXEL_BITS,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int HB = $clog2(MAX_HEIGHT + 1),
    localparam int QW = 2 + 2 * (CW + RW)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [PW-1:0] s_pixel,
    input  logic          cfg_find_minima,
    input  logic [PW-1:0] cfg_range_low,
    input  logic [PW-1:0] cfg_range_high,
    input  logic [WB-1:0] cfg_image_width,
    input  logic [HB-1:0] cfg_image_height,
    output logic          q_push,
    output logic [QW-1:0] q_wr_data,
    input  logic          q_full
);

    import lef_pkg::*;

    typedef struct packed {
        logic rising;
        logic found;
        logic at_col;
    } scan_res_t;

    typedef logic [2:0][PW-1:0] row_t;

    function automatic logic beats_f(input logic mode, input logic [PW-1:0] a,
                                     input logic [PW-1:0] v);
        return mode ? (a < v) : (a > v);
    endfunction

    function automatic logic ties_f(input logic mode, input logic [PW-1:0] a,
                                    input logic [PW-1:0] v);
        return mode ? (a <= v) : (a >= v);
    endfunction

    function automatic logic accept_f(input logic mode, input logic [PW-1:0] lo,
                                      input logic [PW-1:0] hi, input logic [PW-1:0] v,
                                      input row_t up, input row_t mid, input row_t down,
                                      input logic has_up, input logic has_down,
                                      input logic c_gt1);
        logic ok;
        ok = 1'b1;
        if (v < lo || v > hi) begin
            ok = 1'b0;
        end
        if (has_up && (ties_f(mode, up[1], v) || ties_f(mode, up[2], v))) begin
            ok = 1'b0;
        end
        if (has_down && (beats_f(mode, down[1], v) || beats_f(mode, down[2], v))) begin
            ok = 1'b0;
        end
        if (c_gt1 && ((has_up && ties_f(mode, up[0], v)) || beats_f(mode, mid[0], v) ||
                      (has_down && beats_f(mode, down[0], v)))) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // One step of a row scan: runs of equal pixels are skipped, a candidate is
    // taken where the run turns, and the last column is also tested at row end.
    function automatic scan_res_t scan_f(input logic rising, input row_t up,
                                         input row_t mid, input row_t down,
                                         input logic has_up, input logic has_down,
                                         input logic c_zero, input logic c_gt1,
                                         input logic at_end, input logic mode,
                                         input logic [PW-1:0] lo, input logic [PW-1:0] hi);
        scan_res_t res;
        res.rising = rising;
        res.found  = 1'b0;
        res.at_col = 1'b0;
        if (c_zero) begin
            res.rising = 1'b1;
        end else begin
            if (mid[2] != mid[1]) begin
                if (beats_f(mode, mid[2], mid[1])) begin
                    res.rising = 1'b1;
                end else if (rising) begin
                    if (accept_f(mode, lo, hi, mid[1], up, mid, down,
                                 has_up, has_down, c_gt1)) begin
                        res.found = 1'b1;
                    end
                    res.rising = 1'b0;
                end
            end
            if (at_end && res.rising &&
                accept_f(mode, lo, hi, mid[2], up, mid, down, has_up, has_down, c_gt1)) begin
                res.found  = 1'b1;
                res.at_col = 1'b1;
            end
        end
        return res;
    endfunction

    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [WB-1:0] w_clamp;
    logic [HB-1:0] h_clamp;
    logic [CW-1:0] wm1, c_cur;
    logic [RW-1:0] hm1, r_cur;
    logic          end_cur;
    logic          s_accept;

    logic          a_valid_reg, a_valid_next;
    logic [PW-1:0] a_px_reg;
    logic [CW-1:0] a_c_reg;
    logic [RW-1:0] a_r_reg;
    logic          a_end_reg, a_do_d_reg, a_do_l_reg, a_up_d_reg, a_c0_reg, a_cgt1_reg;
    logic          a_adv;

    logic [PW-1:0] rd_one, rd_two;
    logic [2:0][2:0][PW-1:0] win_reg, win_next;
    logic          rise_d_reg, rise_d_next;
    logic          rise_l_reg, rise_l_next;
    scan_res_t     res_d, res_l;
    logic          hit_d, hit_l;
    lef_hits_t     hits;
    logic [CW-1:0] col_d, col_l;

    // Size clamping and position of the arriving pixel.
    always_comb begin
        if (cfg_image_width < WB'(2)) begin
            w_clamp = WB'(2);
        end else if (cfg_image_width > WB'(MAX_WIDTH)) begin
            w_clamp = WB'(MAX_WIDTH);
        end else begin
            w_clamp = cfg_image_width;
        end
        if (cfg_image_height < HB'(1)) begin
            h_clamp = HB'(1);
        end else if (cfg_image_height > HB'(MAX_HEIGHT)) begin
            h_clamp = HB'(MAX_HEIGHT);
        end else begin
            h_clamp = cfg_image_height;
        end
        wm1     = CW'(w_clamp - WB'(1));
        hm1     = RW'(h_clamp - HB'(1));
        c_cur   = (WB'(col_cnt_reg) >= w_clamp) ? wm1 : col_cnt_reg;
        r_cur   = (HB'(row_cnt_reg) >= h_clamp) ? hm1 : row_cnt_reg;
        end_cur = (c_cur == wm1);
    end

    assign a_adv    = a_valid_reg && !q_full;
    assign s_ready  = !a_valid_reg || a_adv;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (s_accept) begin
            if (end_cur) begin
                col_cnt_next = '0;
                row_cnt_next = (r_cur >= hm1) ? '0 : r_cur + RW'(1);
            end else begin
                col_cnt_next = c_cur + CW'(1);
                row_cnt_next = r_cur;
            end
        end
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
    end

    lef_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_one_up (
        .aclk    (aclk),
        .wr_en   (a_adv),
        .wr_addr (a_c_reg),
        .wr_data (a_px_reg),
        .rd_en   (s_accept),
        .rd_addr (c_cur),
        .rd_data (rd_one)
    );

    lef_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_two_up (
        .aclk    (aclk),
        .wr_en   (a_adv),
        .wr_addr (a_c_reg),
        .wr_data (rd_one),
        .rd_en   (s_accept),
        .rd_addr (c_cur),
        .rd_data (rd_two)
    );

    // Window shifts left by one column; the new column is two-up, one-up, current.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = rd_two;
        win_next[1][2] = rd_one;
        win_next[2][2] = a_px_reg;

        res_d = scan_f(rise_d_reg, win_next[0], win_next[1], win_next[2], a_up_d_reg, 1'b1,
                       a_c0_reg, a_cgt1_reg, a_end_reg, cfg_find_minima,
                       cfg_range_low, cfg_range_high);
        res_l = scan_f(rise_l_reg, win_next[1], win_next[2], win_next[2], a_do_d_reg, 1'b0,
                       a_c0_reg, a_cgt1_reg, a_end_reg, cfg_find_minima,
                       cfg_range_low, cfg_range_high);

        rise_d_next = (a_adv && a_do_d_reg) ? res_d.rising : rise_d_reg;
        rise_l_next = (a_adv && a_do_l_reg) ? res_l.rising : rise_l_reg;

        hit_d = a_do_d_reg && res_d.found;
        hit_l = a_do_l_reg && res_l.found;
        col_d = res_d.at_col ? a_c_reg : a_c_reg - CW'(1);
        col_l = res_l.at_col ? a_c_reg : a_c_reg - CW'(1);
    end

    assign hits      = '{delayed_hit: hit_d, last_row_hit: hit_l};
    assign q_push    = a_adv && (hit_d || hit_l);
    assign q_wr_data = {hits, col_d, a_r_reg - RW'(1), col_l, a_r_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
            rise_d_reg  <= 1'b1;
            rise_l_reg  <= 1'b1;
            win_reg     <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            a_valid_reg <= a_valid_next;
            rise_d_reg  <= rise_d_next;
            rise_l_reg  <= rise_l_next;
            if (a_adv) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_px_reg   <= s_pixel;
            a_c_reg    <= c_cur;
            a_r_reg    <= r_cur;
            a_end_reg  <= end_cur;
            a_do_d_reg <= (r_cur != '0);
            a_do_l_reg <= (r_cur == hm1);
            a_up_d_reg <= (r_cur > RW'(1));
            a_c0_reg   <= (c_cur == '0);
            a_cgt1_reg <= (c_cur > CW'(1));
        end
    end

`ifndef ASSERT_OFF
    a_line_ports_apart : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && a_adv) |-> (c_cur != a_c_reg))
        else $error("line store read and write collided on one column");

    a_stage_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !a_adv) |=> (a_valid_reg && $stable(a_c_reg) && $stable(a_px_reg)))
        else $error("stalled pixel stage lost its contents");
`endif

endmodule

// File: rtl/lef_back.sv
// Back end: takes queued per-pixel results and delivers them one per beat.
// Depends on lef_pkg for the hit flags layout.
module lef_back #(
    parameter int CW = 10,
    parameter int RW = 10,
    localparam int QW = 2 + 2 * (CW + RW)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [QW-1:0] q_rd_data,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [CW-1:0] m_column,
    output logic [RW-1:0] m_row,
    output logic          m_last
);

    import lef_pkg::*;

    logic          ent_valid_reg, ent_valid_next;
    logic [QW-1:0] ent_reg;
    logic          second_reg, second_next;
    lef_hits_t     hits;
    logic [CW-1:0] col_d, col_l;
    logic [RW-1:0] row_d, row_l;
    logic          sel_d, out_beat, done;

    assign {hits, col_d, row_d, col_l, row_l} = ent_reg;

    // The delayed-row result goes first when a pixel has both.
    assign sel_d    = !second_reg && hits.delayed_hit;
    assign m_valid  = ent_valid_reg;
    assign m_column = sel_d ? col_d : col_l;
    assign m_row    = sel_d ? row_d : row_l;
    assign m_last   = sel_d ? !hits.last_row_hit : 1'b1;

    assign out_beat = m_valid && m_ready;
    assign done     = out_beat && m_last;
    assign q_pop    = !q_empty && (!ent_valid_reg || done);

    always_comb begin
        ent_valid_next = ent_valid_reg;
        second_next    = second_reg;
        if (q_pop) begin
            ent_valid_next = 1'b1;
            second_next    = 1'b0;
        end else if (done) begin
            ent_valid_next = 1'b0;
            second_next    = 1'b0;
        end else if (out_beat) begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end else begin
            ent_valid_reg <= ent_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_rd_data;
        end
    end

`ifndef ASSERT_OFF
    a_second_only_for_pairs : assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> (ent_valid_reg && hits.delayed_hit && hits.last_row_hit))
        else $error("second result phase without a pair of results");
`endif

endmodule

// File: rtl/local_extrema_finder_core.sv
// Top level of the local extrema finder: APB register file and the front end,
// queue and back end. Depends on lef_pkg, lef_front, lef_queue and lef_back.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_pixel
//  m_        out        m_valid / m_ready    m_column, m_row, m_last
//  APB       in         psel/penable/pready  paddr, pwdata, prdata
//
// One pixel is taken per cycle while the queue has room. A pixel is read from
// both line stores at the edge it is accepted and classified in the pixel
// stage, when the window shifts and both row scans run; the single-port
// line-store write limits this to one pixel a cycle. Results leave one per
// beat, so a pixel with two results occupies the output for two beats, and
// the four-entry queue absorbs such bursts. Reset clears the counters, scan
// flags and queue at once; the line stores are not cleared, which needs no
// sweep. A stall on either side only holds the stage behind it: the front
// keeps accepting while the queue has room, whatever the output side is doing.
module local_extrema_finder_core #(
    parameter int MAX_WIDTH  = lef_pkg::LEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lef_pkg::LEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lef_pkg::LEF_PIXEL_BITS,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PIXEL_BITS-1:0]             s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [CW-1:0]                     m_column,
    output logic [RW-1:0]                     m_row,
    output logic                              m_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lef_pkg::LEF_ADDR_BITS-1:0] paddr,
    input  logic [lef_pkg::LEF_DATA_BITS-1:0] pwdata,
    output logic [lef_pkg::LEF_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    import lef_pkg::*;

    localparam int PW = PIXEL_BITS;
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int QW = 2 + 2 * (CW + RW);

    logic          find_minima_reg;
    logic [PW-1:0] range_low_reg;
    logic [PW-1:0] range_high_reg;
    logic [WB-1:0] image_width_reg;
    logic [HB-1:0] image_height_reg;
    logic          apb_write;
    lef_reg_t      reg_index;

    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_wr_data, q_rd_data;

    // Every access completes in its access cycle.
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;
    assign reg_index = lef_reg_t'(paddr[LEF_ADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_minima_reg  <= 1'b0;
            range_low_reg    <= '0;
            range_high_reg   <= PW'(LEF_RANGE_HIGH_RESET);
            image_width_reg  <= WB'(LEF_IMAGE_WIDTH_RESET);
            image_height_reg <= HB'(LEF_IMAGE_HEIGHT_RESET);
        end else if (apb_write) begin
            case (reg_index)
                REG_FIND_MINIMA: begin
                    find_minima_reg <= pwdata[0];
                end
                REG_RANGE_LOW: begin
                    range_low_reg <= pwdata[PW-1:0];
                end
                REG_RANGE_HIGH: begin
                    range_high_reg <= pwdata[PW-1:0];
                end
                REG_IMAGE_WIDTH: begin
                    image_width_reg <= pwdata[WB-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    image_height_reg <= pwdata[HB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back of the register file; unused addresses read as zero.
    always_comb begin
        case (reg_index)
            REG_FIND_MINIMA:  prdata = LEF_DATA_BITS'(find_minima_reg);
            REG_RANGE_LOW:    prdata = LEF_DATA_BITS'(range_low_reg);
            REG_RANGE_HIGH:   prdata = LEF_DATA_BITS'(range_high_reg);
            REG_IMAGE_WIDTH:  prdata = LEF_DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = LEF_DATA_BITS'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Front end: position counting, line stores, window and the two row scans.
    lef_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .cfg_find_minima  (find_minima_reg),
        .cfg_range_low    (range_low_reg),
        .cfg_range_high   (range_high_reg),
        .cfg_image_width  (image_width_reg),
        .cfg_image_height (image_height_reg),
        .q_push           (q_push),
        .q_wr_data        (q_wr_data),
        .q_full           (q_full)
    );

    // Per-pixel results wait here so that an output stall does not hold pixels.
    lef_queue #(
        .WIDTH (QW),
        .DEPTH (LEF_QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back end: splits a pixel's results into beats, delayed row first.
    lef_back #(
        .CW (CW),
        .RW (RW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rd_data (q_rd_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_column  (m_column),
        .m_row     (m_row),
        .m_last    (m_last)
    );

endmodule

// File: tb/lef_extremum_checker.sv
// Checker for the local extrema finder: watches the pixel, result and APB
// channels, predicts the extrema of each accepted pixel beat and compares.
// Depends on lef_pkg.
module lef_extremum_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_pixel,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [9:0]                        m_column,
    input  logic [9:0]                        m_row,
    input  logic                              m_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [lef_pkg::LEF_ADDR_BITS-1:0] paddr,
    input  logic [lef_pkg::LEF_DATA_BITS-1:0] pwdata,
    output int                                failures,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lef_pkg::*;

    // Columns c-2, c-1 and c of one window row, index 0 being the oldest.
    typedef logic [2:0][7:0] trio_t;

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
        logic       last;
    } extremum_t;

    typedef struct packed {
        logic       found;
        logic       rising;
        logic [9:0] column;
    } scan_t;

    // Register copies.
    logic        minima;
    logic [7:0]  range_lo;
    logic [7:0]  range_hi;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    // Predictor state.
    logic [7:0]  row_two_up [LEF_MAX_WIDTH];
    logic [7:0]  row_one_up [LEF_MAX_WIDTH];
    trio_t       win_top, win_mid, win_bot;
    int unsigned col_pos, row_pos;
    logic        delayed_rising, last_rising;

    extremum_t   extrema_due [$];

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic logic beats(logic [7:0] a, logic [7:0] v);
        return minima ? (a < v) : (a > v);
    endfunction

    function automatic logic ties_or_beats(logic [7:0] a, logic [7:0] v);
        return minima ? (a <= v) : (a >= v);
    endfunction

    function automatic logic passes(logic [7:0] v, trio_t up, trio_t mid, trio_t dn,
                                    logic has_up, logic has_dn, int unsigned c);
        if (v < range_lo || v > range_hi)
            return 1'b0;
        if (has_up && (ties_or_beats(up[1], v) || ties_or_beats(up[2], v)))
            return 1'b0;
        if (has_dn && (beats(dn[1], v) || beats(dn[2], v)))
            return 1'b0;
        if (c > 1 && ((has_up && ties_or_beats(up[0], v)) || beats(mid[0], v) ||
                      (has_dn && beats(dn[0], v))))
            return 1'b0;
        return 1'b1;
    endfunction

    // One step of a row scan; a plateau leaves the run direction as it was.
    function automatic scan_t scan_row(logic rising, trio_t up, trio_t mid, trio_t dn,
                                       logic has_up, logic has_dn, int unsigned c,
                                       logic at_end);
        scan_t res;
        res.found  = 1'b0;
        res.rising = rising;
        res.column = '0;
        if (c == 0) begin
            res.rising = 1'b1;
            return res;
        end
        if (mid[2] != mid[1]) begin
            if (beats(mid[2], mid[1])) begin
                res.rising = 1'b1;
            end else if (res.rising) begin
                if (passes(mid[1], up, mid, dn, has_up, has_dn, c)) begin
                    res.found  = 1'b1;
                    res.column = 10'(c - 1);
                end
                res.rising = 1'b0;
            end
        end
        if (at_end && res.rising && passes(mid[2], up, mid, dn, has_up, has_dn, c)) begin
            res.found  = 1'b1;
            res.column = 10'(c);
        end
        return res;
    endfunction

    task automatic predict_extrema(input logic [7:0] px);
        int unsigned w, h, c, r;
        logic        at_end;
        scan_t       sr;
        extremum_t   hits [2];
        int          n;
        w = (width_reg < 2) ? 2 : ((width_reg > LEF_MAX_WIDTH) ? LEF_MAX_WIDTH : width_reg);
        h = (height_reg < 1) ? 1 :
            ((height_reg > LEF_MAX_HEIGHT) ? LEF_MAX_HEIGHT : height_reg);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        at_end = (c == w - 1);
        n = 0;

        win_top = {row_two_up[c], win_top[2], win_top[1]};
        win_mid = {row_one_up[c], win_mid[2], win_mid[1]};
        win_bot = {px, win_bot[2], win_bot[1]};
        row_two_up[c] = row_one_up[c];
        row_one_up[c] = px;

        // The row above is scanned one row late, once its lower neighbours exist.
        if (r >= 1) begin
            sr = scan_row(delayed_rising, win_top, win_mid, win_bot, r >= 2, 1'b1, c, at_end);
            delayed_rising = sr.rising;
            if (sr.found) begin
                hits[n] = '{column: sr.column, row: 10'(r - 1), last: 1'b0};
                n++;
            end
        end
        // The bottom row of the frame has no lower neighbours and is scanned at once.
        if (r == h - 1) begin
            sr = scan_row(last_rising, win_mid, win_bot, win_bot, r >= 1, 1'b0, c, at_end);
            last_rising = sr.rising;
            if (sr.found) begin
                hits[n] = '{column: sr.column, row: 10'(r), last: 1'b0};
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            hits[k].last = (k == n - 1);
            extrema_due = {extrema_due, hits[k]};
        end

        if (at_end) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic report_mismatch(input string what);
        failures++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_extremum();
        extremum_t want;
        if (extrema_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat column %0d row %0d last %0b",
                                      m_column, m_row, m_last));
        end else begin
            want = extrema_due.pop_front();
            if (m_column !== want.column)
                report_mismatch($sformatf("column %0d, expected %0d (row %0d)",
                                          m_column, want.column, want.row));
            if (m_row !== want.row)
                report_mismatch($sformatf("row %0d, expected %0d (column %0d)",
                                          m_row, want.row, want.column));
            if (m_last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b at column %0d row %0d",
                                          m_last, want.last, want.column, want.row));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            minima         = 1'b0;
            range_lo       = 8'd0;
            range_hi       = 8'(LEF_RANGE_HIGH_RESET);
            width_reg      = 11'(LEF_IMAGE_WIDTH_RESET);
            height_reg     = 11'(LEF_IMAGE_HEIGHT_RESET);
            for (int i = 0; i < LEF_MAX_WIDTH; i++) begin
                row_two_up[i] = 8'd0;
                row_one_up[i] = 8'd0;
            end
            win_top        = '0;
            win_mid        = '0;
            win_bot        = '0;
            col_pos        = 0;
            row_pos        = 0;
            delayed_rising = 1'b1;
            last_rising    = 1'b1;
            extrema_due.delete();
        end else begin
            // A result can never stem from a pixel taken at the same edge.
            if (m_valid && m_ready)
                check_extremum();
            if (psel && penable && pwrite && pready) begin
                case (lef_reg_t'(paddr[4:2]))
                    REG_FIND_MINIMA:  minima     = pwdata[0];
                    REG_RANGE_LOW:    range_lo   = pwdata[7:0];
                    REG_RANGE_HIGH:   range_hi   = pwdata[7:0];
                    REG_IMAGE_WIDTH:  width_reg  = pwdata[10:0];
                    REG_IMAGE_HEIGHT: height_reg = pwdata[10:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_extrema(s_pixel);
        end
        pending = extrema_due.size();
    end

endmodule

// File: tb/tb_local_extrema_finder_core.sv
// Testbench top for local_extrema_finder_core: drives pixel frames, register
// writes and result back-pressure, and gives the verdict.
// Depends on lef_pkg, local_extrema_finder_core and lef_extremum_checker.
module tb_local_extrema_finder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lef_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung. The
    // longest legitimate quiet stretch is the deliberate result hold-off plus a
    // long sender gap, so this leaves a wide margin.
    localparam int CYCLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    // The block classifies a pixel from its registered pixel stage and queues the
    // result; this wait covers a pixel that yields nothing.
    localparam int SETTLE_CYCLES = 8;
    // Pixels for the whole run, directed frames included.
    localparam int TOTAL_ITEMS   = 1950;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [7:0]               s_pixel;
    logic                     m_valid;
    logic                     m_ready;
    logic [9:0]               m_column;
    logic [9:0]               m_row;
    logic                     m_last;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [LEF_ADDR_BITS-1:0] paddr;
    logic [LEF_DATA_BITS-1:0] pwdata;
    logic [LEF_DATA_BITS-1:0] prdata;
    logic                     pready;

    int   failures;
    int   pending;
    int   quiet_cycles;
    int   pixels_sent;
    bit   gaps_on;
    bit   stalls_on;
    bit   hold_off;
    logic [7:0] prev_pixel;
    int   width_reg;
    int   height_reg;

    local_extrema_finder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_pixel  (s_pixel),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_column (m_column),
        .m_row    (m_row),
        .m_last   (m_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lef_extremum_checker u_extremum_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_pixel  (s_pixel),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_column (m_column),
        .m_row    (m_row),
        .m_last   (m_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (failures),
        .pending  (pending)
    );

    // 4 ns clock period.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Watchdog: any beat on the pixel, result or register channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= CYCLE_LIMIT) begin
                $display("** local_extrema_finder_core: FAILED **");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Result side. The long hold-off is timed here, independently of the sender,
    // which keeps offering pixels until the block's queue fills and it stalls.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end else if (stalls_on && $urandom_range(0, 2) == 0) begin
                m_ready = 1'b0;
                repeat (pick_gap() + 1) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
    end

    function automatic int clamp_width(int v);
        return (v < 2) ? 2 : ((v > LEF_MAX_WIDTH) ? LEF_MAX_WIDTH : v);
    endfunction

    function automatic int clamp_height(int v);
        return (v < 1) ? 1 : ((v > LEF_MAX_HEIGHT) ? LEF_MAX_HEIGHT : v);
    endfunction

    // Pixel styles: uniform noise, coarse levels that give many plateaus and
    // ties, a slow random walk that gives long runs, and hard black and white.
    function automatic logic [7:0] make_pixel(int style);
        int v;
        case (style)
            1: v = 40 * $urandom_range(0, 6);
            2: begin
                v = int'(prev_pixel) + int'($urandom_range(0, 12)) - 6;
                v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0:       v = 0;
                    1:       v = 255;
                    default: v = $urandom_range(0, 255);
                endcase
            end
            default: v = $urandom_range(0, 255);
        endcase
        prev_pixel = 8'(v);
        return 8'(v);
    endfunction

    // Every task below starts and ends just after a falling edge. Valid stays
    // high from one pixel to the next unless a gap is drawn.
    task automatic put_pixel(input logic [7:0] px);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pixel = px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input int style);
        for (int i = 0; i < count; i++)
            put_pixel(make_pixel(style));
    endtask

    // Directed pixels, packed first pixel leftmost.
    task automatic send_seq(input int count, input logic [255:0] vals);
        for (int i = 0; i < count; i++)
            put_pixel(vals[8 * (count - 1 - i) +: 8]);
    endtask

    // Wait until every predicted result has left the block, then a little more
    // for a pixel that is still being classified but yields nothing.
    task automatic settle();
        s_valid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input lef_reg_t idx, input int unsigned value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_frame(input int fm, input int lo, input int hi, input int w,
                             input int h);
        write_reg(REG_FIND_MINIMA, fm);
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        width_reg  = w;
        height_reg = h;
    endtask

    task automatic send_frame(input int style);
        send_run(clamp_width(width_reg) * clamp_height(height_reg), style);
    endtask

    // Part of a frame, then the frame is shrunk while the counters may sit past
    // the new bounds, and the remainder of the shrunk frame is sent. Shrinking
    // may read line-store columns that this frame has not yet written.
    task automatic shrink_mid_frame(input int style);
        int w, h, sent_part, col, row, new_w, new_h, c, r;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        sent_part = $urandom_range(1, w * h - 1);
        send_run(sent_part, style);
        col = sent_part % w;
        row = sent_part / w;
        settle();
        new_w = $urandom_range(2, w);
        new_h = $urandom_range(1, h);
        write_reg(REG_IMAGE_WIDTH, new_w);
        write_reg(REG_IMAGE_HEIGHT, new_h);
        width_reg  = new_w;
        height_reg = new_h;
        c = (col < new_w - 1) ? col : new_w - 1;
        r = (row < new_h - 1) ? row : new_h - 1;
        send_run((new_w - c) + (new_h - 1 - r) * new_w, style);
    endtask

    initial begin
        int phase, fm, lo, hi, w, h, frames, style, roll;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_pixel     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gaps_on     = 1'b0;
        stalls_on   = 1'b0;
        hold_off    = 1'b0;
        prev_pixel  = 8'd128;
        pixels_sent = 0;
        width_reg   = LEF_IMAGE_WIDTH_RESET;
        height_reg  = LEF_IMAGE_HEIGHT_RESET;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a 4x3 maxima frame with an in-row peak, a rising run into
        // the end of a row, the extreme pixel values and a plateau on the last
        // row, all with no idling on either side.
        set_frame(0, 0, 255, 4, 3);
        send_seq(12, {8'd10, 8'd50, 8'd50, 8'd20,
                      8'd30, 8'd200, 8'd60, 8'd255,
                      8'd0, 8'd40, 8'd255, 8'd255});
        settle();

        // Minima with a range that excludes both extreme values, now with idling.
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_frame(1, 1, 254, 3, 2);
        send_seq(6, {8'd255, 8'd0, 8'd128, 8'd5, 8'd5, 8'd0});
        settle();

        // Empty range, width and height below their minimum.
        set_frame(0, 200, 100, 1, 0);
        send_seq(2, {8'd0, 8'd255});
        settle();

        // Size cut mid-frame: the column counter is already past the new width
        // and the row becomes the last one, so a single pixel closes the frame.
        set_frame(0, 0, 255, 3, 3);
        send_seq(5, {8'd9, 8'd3, 8'd7, 8'd1, 8'd8});
        settle();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        width_reg  = 2;
        height_reg = 2;
        send_seq(1, {8'd2});
        settle();

        // Largest sizes: one full-width row with the width above its maximum,
        // then a frame with the height above its maximum at the narrowest width,
        // cut to three rows once its row counter has passed the new bound.
        set_frame(1, 0, 255, 2047, 0);
        send_frame(0);
        settle();
        set_frame(0, 0, 255, 0, 2047);
        send_run(24, 2);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 3);
        height_reg = 3;
        send_run(2, 2);
        settle();

        // Random phases of whole frames under random settings, with the odd
        // frame cut short by a mid-frame shrink.
        phase = 0;
        while (pixels_sent < TOTAL_ITEMS) begin
            phase++;
            fm   = $urandom_range(0, 1);
            roll = $urandom_range(0, 19);
            if (roll < 12) begin
                lo = $urandom_range(0, 90);
                hi = $urandom_range(160, 255);
            end else if (roll < 15) begin
                lo = 0;
                hi = 255;
            end else if (roll < 18) begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(0, 255);
            end else begin
                lo = $urandom_range(128, 255);
                hi = $urandom_range(0, 127);
            end
            roll = $urandom_range(0, 9);
            if (roll < 8)
                w = $urandom_range(2, 12);
            else if (roll < 9)
                w = $urandom_range(13, 40);
            else
                w = $urandom_range(0, 1);
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
            frames = $urandom_range(1, 3);
            style  = $urandom_range(0, 3);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                // Back-pressure phase: a dense gap-free stream into a stalled output.
                lo        = 0;
                hi        = 255;
                w         = 8;
                h         = 6;
                frames    = 3;
                style     = 0;
                gaps_on   = 1'b0;
                hold_off  = 1'b1;
            end
            set_frame(fm, lo, hi, w, h);
            for (int f = 0; f < frames; f++) begin
                if (phase != 1 && $urandom_range(0, 9) == 0)
                    shrink_mid_frame(style);
                else
                    send_frame(style);
            end
            settle();
        end

        s_valid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (failures == 0)
            $display("** local_extrema_finder_core: PASSED **");
        else
            $display("** local_extrema_finder_core: FAILED **");
        $finish;
    end

endmodule
